[src/two_bearing_position_fix_defines.svh]
// Assertion macros for the checker file of the position fix block.
`ifndef TWO_BEARING_POSITION_FIX_DEFINES_SVH
`define TWO_BEARING_POSITION_FIX_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define TBPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define TBPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[src/tbpf_pkg.sv]
// Shared constants, tables and types of the two-bearing position fix block.
`timescale 1ns / 1ps

package tbpf_pkg;

  // Fixed-point formats.
  localparam int ANG_FRAC     = 7;
  localparam int SLOPE_FRAC   = 16;
  localparam int CORDIC_ITERS = 16;

  // Angle constants in units of 2^-ANG_FRAC degree.
  localparam int ANG_QUARTER = 90 << ANG_FRAC;
  localparam int ANG_HALF    = 180 << ANG_FRAC;
  localparam int ANG_FULL    = 360 << ANG_FRAC;

  // Slope format: magnitude below 2^(SLOPE_FRAC+14).
  localparam int SLOPE_QW = SLOPE_FRAC + 14;
  localparam int SLOPE_W  = SLOPE_QW + 1;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = SLOPE_W'((64'sd1 <<< SLOPE_QW) - 1);

  // Pairing code of the fourth and last result of a report.
  localparam logic [1:0] PAIR_LAST = 2'd3;

  // Arctangent of 2^-i in units of 2^-20 degree.
  localparam logic [26:0] ATAN_TAB [24] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058, 27'd1876857,
    27'd938658, 27'd469357, 27'd234682, 27'd117342, 27'd58671, 27'd29335,
    27'd14668, 27'd7334, 27'd3667, 27'd1833, 27'd917, 27'd458,
    27'd229, 27'd115, 27'd57, 27'd29, 27'd14, 27'd7
  };

  // Tag that travels with every pairing through the pipeline.
  typedef struct packed {
    logic [1:0] pairing;
    logic       last;
  } tag_t;

endpackage

[src/tbpf_div.sv]
// Pipelined restoring divider with overflow detection, one quotient bit per stage.
`timescale 1ns / 1ps

module tbpf_div #(
  parameter int NUM_W  = 57,
  parameter int DEN_W  = 32,
  parameter int Q_W    = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quot_o,
  output logic              ovf_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  logic              v_q    [Q_W+1];
  logic [NUM_W-1:0]  rem_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic [Q_W-1:0]    quo_q  [Q_W+1];
  logic              ovf_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];
  logic              ovf_d;

  // The quotient overflows when the numerator reaches the divisor times 2^Q_W.
  assign ovf_d = CW'(num_i) >= (CW'(den_i) << Q_W);

  // Entry stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= ovf_d;
      side_q[0] <= side_i;
    end
  end

  // One trial subtraction per stage, most significant quotient bit first.
  for (genvar g = 0; g < Q_W; g++) begin : g_step
    localparam int SH = Q_W - 1 - g;
    logic [CW-1:0] shd;
    logic          fits;

    assign shd  = CW'(den_q[g]) << SH;
    assign fits = CW'(rem_q[g]) >= shd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g+1] <= 1'b0;
      end else if (en_i) begin
        v_q[g+1] <= v_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= fits ? NUM_W'(CW'(rem_q[g]) - shd) : rem_q[g];
        den_q[g+1]  <= den_q[g];
        quo_q[g+1]  <= Q_W'({quo_q[g], fits});
        ovf_q[g+1]  <= ovf_q[g];
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = quo_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign side_o  = side_q[Q_W];

endmodule

[src/tbpf_slope.sv]
// Slope lane: compass angle to math angle, pipelined CORDIC tangent, slope division.
`timescale 1ns / 1ps

module tbpf_slope
  import tbpf_pkg::*;
#(
  parameter int SIDE_W = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [15:0]               heading_i,
  input  logic signed [15:0]        bearing_i,
  input  logic                      mirror_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic signed [SLOPE_W-1:0] slope_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int XW    = 34;
  localparam int ZW    = 29;
  localparam int NUM_W = XW - 1 + SLOPE_FRAC;
  localparam int DEN_W = XW - 1;
  localparam int DSW   = SIDE_W + 2;

  localparam logic signed [19:0] FULL_S    = 20'(ANG_FULL);
  localparam logic signed [17:0] HALF_S    = 18'(ANG_HALF);
  localparam logic signed [17:0] QUARTER_S = 18'(ANG_QUARTER);

  // Stage 0: direct or mirrored bearing added to the heading.
  logic signed [16:0] b_ext, b_abs;
  logic signed [17:0] mir, angle;
  logic signed [19:0] sum_d, sum_q;
  logic               v0_q;
  logic [SIDE_W-1:0]  side0_q;

  assign b_ext = 17'(bearing_i);
  assign b_abs = b_ext[16] ? -b_ext : b_ext;
  assign mir   = HALF_S - 18'(b_abs);
  assign angle = !mirror_i ? 18'(bearing_i) : (bearing_i[15] ? -mir : mir);
  assign sum_d = $signed({4'b0000, heading_i}) + 20'(angle);

  // Stage 1: wrap the compass angle into a full turn.
  logic signed [19:0] w1, w2, w3;
  logic [15:0]        c_q;
  logic               v1_q;
  logic [SIDE_W-1:0]  side1_q;

  assign w1 = sum_q[19] ? sum_q + FULL_S : sum_q;
  assign w2 = (w1 >= FULL_S) ? w1 - FULL_S : w1;
  assign w3 = (w2 >= FULL_S) ? w2 - FULL_S : w2;

  // Stage 2: math angle reduced into [-90, 90) degrees.
  logic signed [17:0] c_s, t0, t1, t2, t3;
  logic signed [ZW-1:0] z_d;

  assign c_s = $signed({2'b00, c_q});
  assign t0  = (c_q != '0 && c_s < QUARTER_S) ? QUARTER_S - c_s : 18'(5 * ANG_QUARTER) - c_s;
  assign t1  = (t0 >= HALF_S) ? t0 - HALF_S : t0;
  assign t2  = (t1 >= HALF_S) ? t1 - HALF_S : t1;
  assign t3  = (t2 >= QUARTER_S) ? t2 - HALF_S : t2;
  assign z_d = ZW'(t3) <<< (20 - ANG_FRAC);

  logic signed [XW-1:0] x_q    [CORDIC_ITERS+1];
  logic signed [XW-1:0] y_q    [CORDIC_ITERS+1];
  logic signed [ZW-1:0] z_q    [CORDIC_ITERS+1];
  logic                 vc_q   [CORDIC_ITERS+1];
  logic [SIDE_W-1:0]    sidec_q[CORDIC_ITERS+1];

  // Angle stages, valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      vc_q[0]  <= 1'b0;
    end else if (en_i) begin
      v0_q     <= valid_i;
      v1_q     <= v0_q;
      vc_q[0]  <= v1_q;
    end
  end

  // Angle stages, payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q      <= sum_d;
      side0_q    <= side_i;
      c_q        <= w3[15:0];
      side1_q    <= side0_q;
      x_q[0]     <= XW'(64'sd1 <<< 30);
      y_q[0]     <= '0;
      z_q[0]     <= z_d;
      sidec_q[0] <= side1_q;
    end
  end

  // CORDIC rotations, one per stage.
  for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_rot
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] at;

    assign dx = y_q[g] >>> g;
    assign dy = x_q[g] >>> g;
    assign at = $signed({2'b00, ATAN_TAB[g]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vc_q[g+1] <= vc_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[g][ZW-1]) begin
          x_q[g+1] <= x_q[g] - dx;
          y_q[g+1] <= y_q[g] + dy;
          z_q[g+1] <= z_q[g] - at;
        end else begin
          x_q[g+1] <= x_q[g] + dx;
          y_q[g+1] <= y_q[g] - dy;
          z_q[g+1] <= z_q[g] + at;
        end
        sidec_q[g+1] <= sidec_q[g];
      end
    end
  end

  // Division operands: |Y| scaled by the slope fraction over a positive X.
  logic signed [XW-1:0] xf, yf, ymag;
  logic                 vert_d, yneg_d;
  logic                 vp_q;
  logic [NUM_W-1:0]     num_q;
  logic [DEN_W-1:0]     den_q;
  logic [DSW-1:0]       dside_q;

  assign xf     = x_q[CORDIC_ITERS];
  assign yf     = y_q[CORDIC_ITERS];
  assign vert_d = xf[XW-1] || xf == '0;
  assign yneg_d = yf[XW-1];
  assign ymag   = yneg_d ? -yf : yf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en_i) begin
      vp_q <= vc_q[CORDIC_ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q   <= {ymag[XW-2:0], {SLOPE_FRAC{1'b0}}};
      den_q   <= vert_d ? DEN_W'(1) : xf[XW-2:0];
      dside_q <= {sidec_q[CORDIC_ITERS], vert_d, yneg_d};
    end
  end

  logic                dv;
  logic [SLOPE_QW-1:0] dq;
  logic                dovf;
  logic [DSW-1:0]      dside;

  tbpf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (SLOPE_QW),
    .SIDE_W(DSW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(vp_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .side_i (dside_q),
    .valid_o(dv),
    .quot_o (dq),
    .ovf_o  (dovf),
    .side_o (dside)
  );

  // Saturate near vertical or on overflow, otherwise apply the sign.
  logic signed [SLOPE_W-1:0] qs, slope_d, slope_q;
  logic                      vo_q;
  logic [SIDE_W-1:0]         side_q;

  assign qs      = $signed({1'b0, dq});
  assign slope_d = (dside[1] || dovf) ? (dside[0] ? -SLOPE_MAX : SLOPE_MAX)
                                      : (dside[0] ? -qs : qs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slope_q <= slope_d;
      side_q  <= dside[DSW-1:2];
    end
  end

  assign valid_o = vo_q;
  assign slope_o = slope_q;
  assign side_o  = side_q;

endmodule

[src/tbpf_isect.sv]
// Intersection of two lines: intercepts, parallel test, split products and dividers.
`timescale 1ns / 1ps

module tbpf_isect
  import tbpf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [SLOPE_W-1:0] m1_i,
  input  logic signed [SLOPE_W-1:0] m2_i,
  input  logic signed [23:0]        ax_i,
  input  logic signed [23:0]        ay_i,
  input  logic signed [23:0]        bx_i,
  input  logic signed [23:0]        by_i,
  input  tag_t                      tag_i,
  input  logic [15:0]               thr_i,
  output logic                      valid_o,
  output logic signed [31:0]        fix_x_o,
  output logic signed [31:0]        fix_y_o,
  output logic                      fix_valid_o,
  output tag_t                      tag_o
);

  localparam int MXW = SLOPE_W + 24;
  localparam int KW  = MXW + 2;
  localparam int LOW = 28;
  localparam int HW  = KW - LOW;
  localparam int PPW = SLOPE_W + HW;
  localparam int PW  = SLOPE_W + KW + 1;
  localparam int NXW = KW + 1;
  localparam int TW  = $bits(tag_t);

  // Stage 0: slope times position, slope difference.
  logic signed [MXW-1:0]     px1_d, px2_d, px1_q, px2_q;
  logic signed [31:0]        d_d, d_q;
  logic signed [23:0]        ay_q, by_q;
  logic signed [SLOPE_W-1:0] m1_q, m2_q, m1_r, m2_r;
  tag_t                      tag0_q, tag1_q, tag2_q, tag3_q, tag4_q, tag5_q;
  logic                      v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;

  assign px1_d = m1_i * ax_i;
  assign px2_d = m2_i * bx_i;
  assign d_d   = 32'(m2_i) - 32'(m1_i);

  // Stage 1: intercepts and the parallel test.
  logic signed [KW-1:0] k1_d, k2_d, k1_q, k2_q;
  logic                 dneg_d;
  logic [31:0]          dmag;
  logic [47:0]          lhs, rhs;
  logic                 par_d;
  logic                 dneg1_q, dneg2_q, dneg3_q, dneg4_q, par1_q, par2_q, par3_q, par4_q;

  assign k1_d   = (KW'(ay_q) <<< SLOPE_FRAC) - KW'(px1_q);
  assign k2_d   = (KW'(by_q) <<< SLOPE_FRAC) - KW'(px2_q);
  assign dneg_d = d_q[31];
  assign dmag   = dneg_d ? 32'(-d_q) : 32'(d_q);
  assign lhs    = {dmag, 16'h0000};
  assign rhs    = 48'({thr_i, {SLOPE_FRAC{1'b0}}});
  assign par_d  = (d_q == '0) || (lhs < rhs);

  // Stage 2: products split at the low part of each intercept.
  logic signed [HW-1:0]  k1_hi, k2_hi, k1_lo, k2_lo;
  logic signed [PPW-1:0] pa_hi_q, pa_lo_q, pb_hi_q, pb_lo_q;
  logic signed [NXW-1:0] nx_d, nx2_q, nx3_q, nx4_q;

  assign k1_hi = k1_q[KW-1:LOW];
  assign k2_hi = k2_q[KW-1:LOW];
  assign k1_lo = $signed(HW'(k1_q[LOW-1:0]));
  assign k2_lo = $signed(HW'(k2_q[LOW-1:0]));
  assign nx_d  = NXW'(k1_q) - NXW'(k2_q);

  // Stage 3: recombine partial products; stage 4: difference of products.
  logic signed [PW-1:0] pa_d, pb_d, pa_q, pb_q, ny_q;

  assign pa_d = (PW'(pa_hi_q) <<< LOW) + PW'(pa_lo_q);
  assign pb_d = (PW'(pb_hi_q) <<< LOW) + PW'(pb_lo_q);

  // Stage 5: magnitudes and result signs for both dividers.
  logic [NXW-2:0] nxmag_q;
  logic [PW-2:0]  nymag_q;
  logic           negx_q, negy_q, par5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 0.
      px1_q   <= px1_d;
      px2_q   <= px2_d;
      d_q     <= d_d;
      ay_q    <= ay_i;
      by_q    <= by_i;
      m1_q    <= m1_i;
      m2_q    <= m2_i;
      tag0_q  <= tag_i;
      // Stage 1.
      k1_q    <= k1_d;
      k2_q    <= k2_d;
      dneg1_q <= dneg_d;
      par1_q  <= par_d;
      m1_r    <= m1_q;
      m2_r    <= m2_q;
      tag1_q  <= tag0_q;
      // Stage 2.
      pa_hi_q <= m2_r * k1_hi;
      pa_lo_q <= m2_r * k1_lo;
      pb_hi_q <= m1_r * k2_hi;
      pb_lo_q <= m1_r * k2_lo;
      nx2_q   <= nx_d;
      dneg2_q <= dneg1_q;
      par2_q  <= par1_q;
      tag2_q  <= tag1_q;
      // Stage 3.
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      nx3_q   <= nx2_q;
      dneg3_q <= dneg2_q;
      par3_q  <= par2_q;
      tag3_q  <= tag2_q;
      // Stage 4.
      ny_q    <= pa_q - pb_q;
      nx4_q   <= nx3_q;
      dneg4_q <= dneg3_q;
      par4_q  <= par3_q;
      tag4_q  <= tag3_q;
      // Stage 5.
      nxmag_q <= nx4_q[NXW-1] ? (NXW-1)'(-nx4_q) : nx4_q[NXW-2:0];
      nymag_q <= ny_q[PW-1] ? (PW-1)'(-ny_q) : ny_q[PW-2:0];
      negx_q  <= nx4_q[NXW-1] ^ dneg4_q;
      negy_q  <= ny_q[PW-1] ^ dneg4_q;
      par5_q  <= par4_q;
      tag5_q  <= tag4_q;
    end
  end

  // Dividers for both coordinates run in lockstep; the divisor is delayed
  // to line up with the stage 5 numerators.
  logic [31:0]   dmag5;
  logic [31:0]   dmag_q [5];
  logic          vx, vy, ovfx, ovfy;
  logic [30:0]   qx, qy;
  logic [TW+1:0] sidex;
  logic          sidey;

  assign dmag5 = dmag_q[4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q[0] <= dmag;
      dmag_q[1] <= dmag_q[0];
      dmag_q[2] <= dmag_q[1];
      dmag_q[3] <= dmag_q[2];
      dmag_q[4] <= dmag_q[3];
    end
  end

  tbpf_div #(
    .NUM_W (NXW - 1),
    .DEN_W (32),
    .Q_W   (31),
    .SIDE_W(TW + 2)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(v5_q),
    .num_i  (nxmag_q),
    .den_i  (dmag5),
    .side_i ({tag5_q, par5_q, negx_q}),
    .valid_o(vx),
    .quot_o (qx),
    .ovf_o  (ovfx),
    .side_o (sidex)
  );

  tbpf_div #(
    .NUM_W (PW - 1),
    .DEN_W (32),
    .Q_W   (31),
    .SIDE_W(1)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(v5_q),
    .num_i  (nymag_q),
    .den_i  (dmag5),
    .side_i (negy_q),
    .valid_o(vy),
    .quot_o (qy),
    .ovf_o  (ovfy),
    .side_o (sidey)
  );

  // Signed, saturated coordinates; zero for parallel lines.
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

  logic               par_o;
  logic signed [31:0] sqx, sqy;

  assign par_o = sidex[1];
  assign sqx   = $signed({1'b0, qx});
  assign sqy   = $signed({1'b0, qy});

  assign fix_x_o = par_o ? '0 : ovfx ? (sidex[0] ? C_MIN : C_MAX) : (sidex[0] ? -sqx : sqx);
  assign fix_y_o = par_o ? '0 : ovfy ? (sidey ? C_MIN : C_MAX) : (sidey ? -sqy : sqy);
  assign fix_valid_o = !par_o;
  assign tag_o       = tag_t'(sidex[TW+1:2]);
  assign valid_o     = vx && vy;

endmodule

[src/two_bearing_position_fix.sv]
// Top level of the two-bearing position fix block.
`timescale 1ns / 1ps
// Usage:
// The input stream carries one report per transaction: both vehicle positions,
// compass headings and relative source bearings. For every report the block
// returns four results on the output stream, pairings 0, 1, 2 and 3 in order,
// each with the intersection of the first vehicle's line with the second's
// (direct or front/back mirrored bearing), a flag for non-parallel lines and
// tlast on the fourth result.
// Throughput: one result per cycle while the receiver does not stall; the report
// register issues one pairing per cycle into the pipeline while it advances, and
// takes the next report together with the last pairing of the one before. The
// first result of a report passes the 16 CORDIC stages, the 31 stages of the
// slope divider and the 32 stages of the coordinate dividers.
// The configuration channel writes the parallel threshold; it is always ready.
// Reset clears all valid bits and sets the threshold to 1.
// When the receiver stalls, the whole pipeline holds and input tready drops;
// nothing is lost or repeated.
module two_bearing_position_fix
  import tbpf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input stream: a_x, a_y, a_heading, a_bearing, b_x, b_y, b_heading, b_bearing.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [159:0] s_axis_tdata_i,
  // Output stream: tdata holds fix_x, fix_y; tuser holds fix_valid, pairing.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o,
  // Configuration write channel: parallel_threshold.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  logic        en;
  logic        in_acc;
  logic [15:0] thr_q;

  // Pipeline advances whenever the output register can take a result.
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd1;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // Report register and pairing sequencer.
  logic         busy_q;
  logic [1:0]   cnt_q;
  logic [159:0] item_q;
  logic         issue;

  assign s_axis_tready_o = en && (!busy_q || cnt_q == PAIR_LAST);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign issue           = busy_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (issue) begin
      busy_q <= cnt_q != PAIR_LAST;
      cnt_q  <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= s_axis_tdata_i;
    end
  end

  // Unpack the held report.
  logic signed [23:0] ax, ay, bx, by;
  logic [15:0]        ah, bh;
  logic signed [15:0] ab, bb;
  tag_t               tag_in;

  assign ax = item_q[23:0];
  assign ay = item_q[47:24];
  assign ah = item_q[63:48];
  assign ab = item_q[79:64];
  assign bx = item_q[103:80];
  assign by = item_q[127:104];
  assign bh = item_q[143:128];
  assign bb = item_q[159:144];

  assign tag_in.pairing = cnt_q;
  assign tag_in.last    = cnt_q == PAIR_LAST;

  // Slope lanes for the first and second vehicle.
  localparam int TW  = $bits(tag_t);
  localparam int SAW = TW + 48;

  logic                      va, vb;
  logic signed [SLOPE_W-1:0] ma, mb;
  logic [SAW-1:0]            sa;
  logic [47:0]               sb;

  tbpf_slope #(
    .SIDE_W(SAW)
  ) u_slope_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (busy_q),
    .heading_i(ah),
    .bearing_i(ab),
    .mirror_i (cnt_q[1]),
    .side_i   ({tag_in, ay, ax}),
    .valid_o  (va),
    .slope_o  (ma),
    .side_o   (sa)
  );

  tbpf_slope #(
    .SIDE_W(48)
  ) u_slope_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (busy_q),
    .heading_i(bh),
    .bearing_i(bb),
    .mirror_i (cnt_q[0]),
    .side_i   ({by, bx}),
    .valid_o  (vb),
    .slope_o  (mb),
    .side_o   (sb)
  );

  // Line intersection.
  logic               vi, fv;
  logic signed [31:0] fx, fy;
  tag_t               tag_out;

  tbpf_isect u_isect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (va && vb),
    .m1_i       (ma),
    .m2_i       (mb),
    .ax_i       (sa[23:0]),
    .ay_i       (sa[47:24]),
    .bx_i       (sb[23:0]),
    .by_i       (sb[47:24]),
    .tag_i      (tag_t'(sa[SAW-1:48])),
    .thr_i      (thr_q),
    .valid_o    (vi),
    .fix_x_o    (fx),
    .fix_y_o    (fy),
    .fix_valid_o(fv),
    .tag_o      (tag_out)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (en) begin
      m_axis_tvalid_o <= vi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata_o <= {fy, fx};
      m_axis_tuser_o <= {tag_out.pairing, fv};
      m_axis_tlast_o <= tag_out.last;
    end
  end

endmodule

[src/tbpf_checker.sv]
// Port-level checker for the position fix block, bound to the top level.
`timescale 1ns / 1ps
`include "two_bearing_position_fix_defines.svh"

module tbpf_checker
  import tbpf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Pairing expected on the next output transaction.
  logic [1:0] exp_pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pair_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      exp_pair_q <= m_axis_tuser_o[2:1] + 2'd1;
    end
  end

  // A stalled result keeps its contents.
  `TBPF_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled output changed")

  // Pairings come in order and wrap after the last one.
  `TBPF_ASSERT_ALWAYS(a_pair_order, m_axis_tvalid_o |-> m_axis_tuser_o[2:1] == exp_pair_q, "pairing out of order")

  // The last flag marks exactly the fourth pairing.
  `TBPF_ASSERT_ALWAYS(a_last_pair, m_axis_tvalid_o |-> m_axis_tlast_o == (m_axis_tuser_o[2:1] == PAIR_LAST), "last flag on wrong pairing")

  // Parallel lines give a zero position.
  `TBPF_ASSERT_ALWAYS(a_par_zero, m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == 64'd0, "parallel result not zero")

endmodule

bind two_bearing_position_fix tbpf_checker u_tbpf_checker (.*);

[tb/tb_two_bearing_position_fix.sv]
// Self-checking testbench for the two-bearing position fix block.
`timescale 1ns / 1ps

module tb_two_bearing_position_fix;
  import tbpf_pkg::*;

  localparam int  LATENCY_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;

  // One report from the two vehicles.
  typedef struct {
    logic [23:0] ax, ay, bx, by;
    logic [15:0] ahdg, abrg, bhdg, bbrg;
  } report_t;

  // One expected intersection result.
  typedef struct {
    logic signed [31:0] fx, fy;
    logic               ok;
    logic [1:0]         pair;
    logic               last;
  } fix_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [159:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  fix_t    pending_fixes[$];
  logic [15:0] threshold_copy = 16'd1;
  int      error_count = 0;
  longint  cycle_count = 0;
  int      hold_left = 0;
  int      sink_busy = 0;
  bit      idling_on = 1'b1;

  two_bearing_position_fix dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Line slope in 2^-16 units for a heading plus a relative angle.
  function automatic longint line_slope(longint hdg, longint ang);
    longint c, t, x, y, z, dx, dy, q, smax;
    smax = longint'(SLOPE_MAX);
    c = (hdg + ang) % ANG_FULL;
    if (c < 0) c += ANG_FULL;
    t = (c > 0 && c < ANG_QUARTER) ? ANG_QUARTER - c : 5 * ANG_QUARTER - c;
    t = t % ANG_HALF;
    if (t >= ANG_QUARTER) t -= ANG_HALF;
    z = t * (longint'(1) << (20 - ANG_FRAC));
    x = longint'(1) << 30;
    y = 0;
    // Rotation-mode CORDIC toward zero residual angle.
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end
    end
    if (x <= 0) return (y >= 0) ? smax : -smax;
    q = (y * (longint'(1) << SLOPE_FRAC)) / x;
    if (q > smax) q = smax;
    if (q < -smax) q = -smax;
    return q;
  endfunction

  // Front/back mirror of a bearing, keeping its sign.
  function automatic longint mirrored(longint b);
    longint mag;
    mag = (b < 0) ? -b : b;
    return (b < 0) ? -(ANG_HALF - mag) : ANG_HALF - mag;
  endfunction

  // Truncating division saturated to 32 bit signed.
  function automatic logic signed [31:0] div_sat(logic signed [127:0] n,
                                                 logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if (q > 128'sd2147483647) return 32'sh7fffffff;
    if (q < -128'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  // Works out the four intersections of one report and queues them.
  function automatic void queue_fixes(report_t r);
    longint ax, ay, bx, by, m1, m2, k1, k2, d;
    longint ma[2], mb[2], ka[2], kb[2];
    logic signed [127:0] m1w, m2w, k1w, k2w;
    fix_t f;
    ax = longint'($signed(r.ax));
    ay = longint'($signed(r.ay));
    bx = longint'($signed(r.bx));
    by = longint'($signed(r.by));
    for (int s = 0; s < 2; s++) begin
      ma[s] = line_slope(longint'(r.ahdg), s ? mirrored(longint'($signed(r.abrg)))
                                             : longint'($signed(r.abrg)));
      mb[s] = line_slope(longint'(r.bhdg), s ? mirrored(longint'($signed(r.bbrg)))
                                             : longint'($signed(r.bbrg)));
      ka[s] = ay * (longint'(1) << SLOPE_FRAC) - ma[s] * ax;
      kb[s] = by * (longint'(1) << SLOPE_FRAC) - mb[s] * bx;
    end
    for (int p = 0; p < 4; p++) begin
      m1 = ma[p >> 1]; k1 = ka[p >> 1];
      m2 = mb[p & 1];  k2 = kb[p & 1];
      d = m2 - m1;
      f.fx = '0;
      f.fy = '0;
      f.ok = 1'b0;
      f.pair = 2'(p);
      f.last = (2'(p) == PAIR_LAST);
      if (d != 0 && !((((d < 0) ? -d : d) << 16) <
                      (longint'(threshold_copy) << SLOPE_FRAC))) begin
        m1w = m1; m2w = m2; k1w = k1; k2w = k2;
        f.ok = 1'b1;
        f.fx = div_sat(k1w - k2w, m2w - m1w);
        f.fy = div_sat(m2w * k1w - m1w * k2w, m2w - m1w);
      end
      pending_fixes.push_back(f);
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    fix_t f;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_fixes.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        f = pending_fixes.pop_front();
        if ($signed(m_axis_tdata_o[31:0]) !== f.fx)
          report_mismatch("fix_x", $signed(m_axis_tdata_o[31:0]), f.fx);
        if ($signed(m_axis_tdata_o[63:32]) !== f.fy)
          report_mismatch("fix_y", $signed(m_axis_tdata_o[63:32]), f.fy);
        if (m_axis_tuser_o[0] !== f.ok)
          report_mismatch("fix_valid", m_axis_tuser_o[0], f.ok);
        if (m_axis_tuser_o[2:1] !== f.pair)
          report_mismatch("pairing", m_axis_tuser_o[2:1], f.pair);
        if (m_axis_tlast_o !== f.last)
          report_mismatch("last_fix", m_axis_tlast_o, f.last);
      end
    end
  end

  // Receiver readiness: random stalls plus a long hold when requested.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (sink_busy > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_busy--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (idling_on && $urandom_range(0, 99) < 30) sink_busy = random_gap();
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one report, waits for its transaction, then idles for the given gap.
  task automatic send_report(report_t r, int gap);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.bbrg, r.bhdg, r.by, r.bx, r.abrg, r.ahdg, r.ay, r.ax};
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_fixes(r);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    if (s_axis_tvalid_i) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [15:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold_copy = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic report_t random_report();
    report_t r;
    // Mostly nearby vehicles and legal angles; sometimes any bit pattern.
    if ($urandom_range(0, 3) == 0) begin
      r.ax = 24'($urandom); r.ay = 24'($urandom);
      r.bx = 24'($urandom); r.by = 24'($urandom);
    end else begin
      r.ax = 24'($signed($urandom_range(0, 512000)) - 256000);
      r.ay = 24'($signed($urandom_range(0, 512000)) - 256000);
      r.bx = 24'($signed($urandom_range(0, 512000)) - 256000);
      r.by = 24'($signed($urandom_range(0, 512000)) - 256000);
    end
    if ($urandom_range(0, 7) == 0) begin
      r.ahdg = 16'($urandom); r.bhdg = 16'($urandom);
      r.abrg = 16'($urandom); r.bbrg = 16'($urandom);
    end else begin
      r.ahdg = 16'($urandom_range(0, 46079));
      r.bhdg = 16'($urandom_range(0, 46079));
      r.abrg = 16'($signed($urandom_range(0, 46080)) - 23040);
      r.bbrg = 16'($signed($urandom_range(0, 46080)) - 23040);
    end
    return r;
  endfunction

  function automatic report_t make_report(int ax, int ay, int ah, int ab,
                                          int bx, int by, int bh, int bb);
    report_t r;
    r.ax = 24'(ax); r.ay = 24'(ay); r.ahdg = 16'(ah); r.abrg = 16'(ab);
    r.bx = 24'(bx); r.by = 24'(by); r.bhdg = 16'(bh); r.bbrg = 16'(bb);
    return r;
  endfunction

  // Field extremes, wrap cases, vertical and parallel lines.
  task automatic test_directed();
    send_report(make_report(0, 0, 0, 0, 25600, 0, 0, 0), 0);
    send_report(make_report(0, 0, 5760, 0, 25600, 25600, 17280, 0), 1);
    send_report(make_report(-8388608, -8388608, 0, -23040,
                            8388607, 8388607, 46079, 23040), 0);
    send_report(make_report(8388607, -8388608, 46079, 23040,
                            -8388608, 8388607, 0, -23040), 2);
    // Same heading and bearing: identical slopes where both bearings are direct or both mirrored.
    send_report(make_report(0, 0, 5000, 1000, 12800, 0, 5000, 1000), 0);
    // Heading plus bearing below zero wraps up by a full turn.
    send_report(make_report(1000, 2000, 0, -100, -3000, 500, 100, -23040), 0);
    // Exactly east for both vehicles, from the heading on one and the bearing on the other.
    send_report(make_report(0, 0, 11520, 0, 0, 25600, 0, 11520), 3);
    // Heading outside one turn, full-width patterns.
    send_report(make_report(100, 100, 65535, -1, -100, 100, 46080, 1), 0);
    send_report(make_report(0, 0, 32768, -32768, 256, 256, 65535, 32767), 0);
    send_report(make_report(-1, -1, 23040, 23039, 1, 1, 23039, -23039), 0);
    send_report(make_report(0, 0, 11519, 1, 500, 0, 11521, -1), 0);
    send_report(make_report(8388607, 0, 34560, 0, 0, 8388607, 0, 0), 15);
    send_report(make_report(5, -5, 1, 0, -5, 5, 46079, 0), 0);
  endtask

  // Threshold settings: zero, maximum, random, back to the reset value.
  task automatic test_threshold();
    logic [15:0] values[4];
    values = '{16'd0, 16'hffff, 16'($urandom), 16'd1};
    foreach (values[i]) begin
      write_threshold(values[i]);
      send_report(make_report(0, 0, 5000, 1000, 12800, 0, 5000, 1000), 0);
      send_report(make_report(0, 0, 5000, 1000, 12800, 0, 5001, 1000), 0);
      for (int n = 0; n < 6; n++) send_report(random_report(), random_gap());
    end
  endtask

  // Long receiver hold while reports keep coming, then a full drain.
  task automatic test_backpressure();
    @(posedge clk_i);
    hold_left = 400;
    for (int n = 0; n < 40; n++) send_report(random_report(), 0);
    wait_drained();
  endtask

  // Random reports with and without idling on both sides.
  task automatic test_random();
    for (int n = 0; n < 170; n++) begin
      idling_on = !(n >= 60 && n < 100);
      send_report(random_report(), idling_on ? random_gap() : 0);
    end
    idling_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_threshold();
    test_backpressure();
    test_random();
    wait_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tbpf_pkg.sv
src/tbpf_div.sv
src/tbpf_slope.sv
src/tbpf_isect.sv
src/two_bearing_position_fix.sv
src/tbpf_checker.sv
tb/tb_two_bearing_position_fix.sv
